// File: rtl/rci_pkg.sv
package rci_pkg;

    // Field widths and fixed-point format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 24;
    localparam int TOL_W     = 25;
    localparam int DIST_W    = 31;

    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1678);
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    // Divider shape: |numerator| * 2^FRAC_BITS over a body or cap denominator
    localparam int DIV_N_W   = 42 + FRAC_BITS;
    localparam int DIV_D_W   = 41;
    localparam int DIV_Q_W   = DIST_W;
    localparam int DIV_LAT   = DIV_Q_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic        [DIST_W-1:0]  max_distance;
    } ray_word_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic              surface;
    } hit_word_t;

endpackage

// File: rtl/rci_div.sv
module rci_div (
    input  logic                              clk,
    input  logic                              en,
    input  logic [rci_pkg::DIV_N_W-1:0]       n_mag,
    input  logic [rci_pkg::DIV_D_W-1:0]       d_mag,
    input  logic                              neg,
    output logic signed [rci_pkg::COORD_W-1:0] quo
);
    import rci_pkg::*;

    localparam int CMP_W = DIV_D_W + DIV_Q_W;

    logic [DIV_N_W-1:0] rem_reg [0:DIV_Q_W-2];
    logic [DIV_D_W-1:0] d_reg   [0:DIV_Q_W-2];
    logic [DIV_Q_W-1:0] q_reg   [0:DIV_Q_W-1];
    logic               neg_reg [0:DIV_Q_W-1];
    logic               sat_reg [0:DIV_Q_W-1];
    logic signed [COORD_W-1:0] quo_reg;

    // quotient of 2^31 or more saturates
    logic sat_in;
    assign sat_in = CMP_W'(n_mag) >= (CMP_W'(d_mag) << DIV_Q_W);

    // one restoring step per stage, quotient msb first
    for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
        localparam int B = DIV_Q_W - 1 - k;
        logic [DIV_N_W-1:0] rem_in;
        logic [DIV_D_W-1:0] d_in;
        logic [DIV_Q_W-1:0] q_in;
        logic [DIV_Q_W-1:0] q_new;
        logic               neg_in;
        logic               sat_k;
        logic [CMP_W-1:0]   shifted;
        logic               ge;

        if (k == 0) begin : g_first
            assign rem_in = n_mag;
            assign d_in   = d_mag;
            assign q_in   = '0;
            assign neg_in = neg;
            assign sat_k  = sat_in;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign neg_in = neg_reg[k-1];
            assign sat_k  = sat_reg[k-1];
        end

        always_comb
        begin
            shifted  = CMP_W'(d_in) << B;
            ge       = CMP_W'(rem_in) >= shifted;
            q_new    = q_in;
            q_new[B] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_new;
                neg_reg[k] <= neg_in;
                sat_reg[k] <= sat_k;
            end
        end

        if (k < DIV_Q_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? DIV_N_W'(CMP_W'(rem_in) - shifted) : rem_in;
                    d_reg[k]   <= d_in;
                end
            end
        end
    end

    // saturate and apply sign
    logic signed [COORD_W-1:0] mag_s;
    assign mag_s = $signed({1'b0, sat_reg[DIV_Q_W-1] ? DIST_MAX : q_reg[DIV_Q_W-1]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[DIV_Q_W-1] ? -mag_s : mag_s;
        end
    end

    assign quo = quo_reg;

endmodule

// File: rtl/ray_cone_intersect.sv
// Ray against unit cone (tip y=+0.5, base disc r=0.5 at y=-0.5), Q8.24.
// Input channel: ray_valid / ray_stall / ray carry one ray word (origin,
// direction, exclusive distance limit). Output channel: hit_valid /
// hit_stall / hit_info carry one result word per ray: hit flag, nearest
// distance (all ones when no hit) and surface (1 = base cap).
// A word moves at a clock edge with valid high and stall low.
// One ray is accepted every cycle while the output word is not stalled.
// The depth is set by the 41-stage square root (one result bit per stage)
// and the dividers (one quotient bit per stage).
// The whole pipeline holds when the output word is stalled; ray_stall then
// goes high and nothing is lost or repeated.
// cfg_we / cfg_data write the hit tolerance; change it only while idle.
// Reset clears all valid bits and sets the tolerance to 1678.
module ray_cone_intersect (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        ray_valid,
    output logic                        ray_stall,
    input  rci_pkg::ray_word_t          ray,
    output logic                        hit_valid,
    input  logic                        hit_stall,
    output rci_pkg::hit_word_t          hit_info,
    input  logic                        cfg_we,
    input  logic [rci_pkg::TOL_W-1:0]   cfg_data
);
    import rci_pkg::*;

    localparam int PROD_W   = 2 * COORD_W;
    localparam int ABC_W    = 41;
    localparam int LO_W     = 21;
    localparam int HI_W     = ABC_W - LO_W;
    localparam int RAD_W    = 2 * ABC_W;
    localparam int SQ_STEPS = RAD_W / 2;
    localparam int SQ_W     = ABC_W;
    localparam int SQ_REM_W = SQ_W + 3;
    localparam int NUM_W    = ABC_W + 2;
    localparam int CN_W     = COORD_W + 2;
    localparam int PT_W     = PROD_W + 1;
    localparam int XM_W     = 2 * FRAC_BITS;
    localparam int XH_W     = XM_W / 2;
    localparam int R2_W     = 4 * FRAC_BITS;
    localparam int CMP_W    = DIST_W + 2;

    localparam int L_ABC    = 2;
    localparam int L_PART   = L_ABC + 1;
    localparam int L_COMB   = L_PART + 1;
    localparam int L_DISC   = L_COMB + 1;
    localparam int L_SQ_END = L_DISC + SQ_STEPS;
    localparam int L_NUM    = L_SQ_END + 1;
    localparam int L_DIV    = L_NUM + DIV_LAT;
    localparam int L_TPROD  = L_DIV + 1;
    localparam int L_HITPT  = L_TPROD + 1;
    localparam int L_RPART  = L_HITPT + 1;
    localparam int L_R2     = L_RPART + 1;
    localparam int L_OUT    = L_R2 + 1;

    localparam logic signed [69:0]    ONE_SQ   = 70'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [CN_W-1:0] HALF_ONE = CN_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PT_W-1:0] HALF2    = PT_W'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic [R2_W-1:0]        R2_LIM   = R2_W'(1) << (4 * FRAC_BITS - 2);

    function automatic logic [ABC_W-1:0] mag_abc(input logic signed [ABC_W-1:0] v);
        return v[ABC_W-1] ? ABC_W'(-v) : ABC_W'(v);
    endfunction

    // global advance: every stage moves unless the output word is held
    logic adv;
    assign adv       = !(hit_valid && hit_stall);
    assign ray_stall = !adv;

    // tolerance register
    logic [TOL_W-1:0] tol_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_data;
        end
    end

    // valid bits travel with the data
    logic [L_OUT:1] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[L_OUT-1:1], ray_valid};
        end
    end

    // ray word delay line
    ray_word_t ray_reg [1:L_R2];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray_reg[1] <= ray;
        end
    end
    for (genvar l = 2; l <= L_R2; l++) begin : g_ray_line
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ray_reg[l] <= ray_reg[l-1];
            end
        end
    end

    // stage 1: coordinate products
    logic signed [PROD_W-1:0] p_dxx_reg, p_dzz_reg, p_dyy_reg;
    logic signed [PROD_W-1:0] p_pxdx_reg, p_pzdz_reg, p_pydy_reg;
    logic signed [PROD_W-1:0] p_pxx_reg, p_pzz_reg, p_pyy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_dxx_reg  <= ray.dir_x * ray.dir_x;
            p_dzz_reg  <= ray.dir_z * ray.dir_z;
            p_dyy_reg  <= ray.dir_y * ray.dir_y;
            p_pxdx_reg <= ray.origin_x * ray.dir_x;
            p_pzdz_reg <= ray.origin_z * ray.dir_z;
            p_pydy_reg <= ray.origin_y * ray.dir_y;
            p_pxx_reg  <= ray.origin_x * ray.origin_x;
            p_pzz_reg  <= ray.origin_z * ray.origin_z;
            p_pyy_reg  <= ray.origin_y * ray.origin_y;
        end
    end

    // stage 2: quadratic coefficients, floored
    logic signed [67:0] t4;
    logic signed [68:0] t8;
    logic signed [69:0] t16;
    always_comb
    begin
        t4  = (68'(p_dxx_reg) <<< 2) + (68'(p_dzz_reg) <<< 2) - 68'(p_dyy_reg);
        t8  = (69'(p_pxdx_reg) <<< 3) + (69'(p_pzdz_reg) <<< 3)
            - (69'(p_pydy_reg) <<< 1) + (69'(ray_reg[1].dir_y) <<< FRAC_BITS);
        t16 = (70'(p_pxx_reg) <<< 4) + (70'(p_pzz_reg) <<< 4) - (70'(p_pyy_reg) <<< 2)
            + (70'(ray_reg[1].origin_y) <<< (FRAC_BITS + 2)) - ONE_SQ;
    end

    logic signed [ABC_W-1:0] a_reg [L_ABC:L_SQ_END];
    logic signed [ABC_W-1:0] h_reg [L_ABC:L_SQ_END];
    logic signed [ABC_W-1:0] c_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg[L_ABC] <= t4[FRAC_BITS+2 +: ABC_W];
            h_reg[L_ABC] <= t8[FRAC_BITS+3 +: ABC_W];
            c_reg        <= t16[FRAC_BITS+4 +: ABC_W];
        end
    end
    for (genvar l = L_ABC + 1; l <= L_SQ_END; l++) begin : g_ah_line
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_reg[l] <= a_reg[l-1];
                h_reg[l] <= h_reg[l-1];
            end
        end
    end

    // stage 3: partial products of h*h and a*c
    logic [ABC_W-1:0] hm, am, cm;
    assign hm = mag_abc(h_reg[L_ABC]);
    assign am = mag_abc(a_reg[L_ABC]);
    assign cm = mag_abc(c_reg);

    logic [2*LO_W-1:0]    hll_reg, acll_reg;
    logic [LO_W+HI_W-1:0] hlh_reg, aclh_reg, achl_reg;
    logic [2*HI_W-1:0]    hhh_reg, achh_reg;
    logic                 acneg3_reg, anz3_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hll_reg    <= hm[LO_W-1:0] * hm[LO_W-1:0];
            hlh_reg    <= hm[LO_W-1:0] * hm[ABC_W-1:LO_W];
            hhh_reg    <= hm[ABC_W-1:LO_W] * hm[ABC_W-1:LO_W];
            acll_reg   <= am[LO_W-1:0] * cm[LO_W-1:0];
            aclh_reg   <= am[LO_W-1:0] * cm[ABC_W-1:LO_W];
            achl_reg   <= am[ABC_W-1:LO_W] * cm[LO_W-1:0];
            achh_reg   <= am[ABC_W-1:LO_W] * cm[ABC_W-1:LO_W];
            acneg3_reg <= a_reg[L_ABC][ABC_W-1] ^ c_reg[ABC_W-1];
            anz3_reg   <= a_reg[L_ABC] != '0;
        end
    end

    // stage 4: full magnitudes
    logic [RAD_W-1:0] hsq_reg, acm_reg;
    logic             acneg4_reg, anz4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hsq_reg    <= (RAD_W'(hhh_reg) << (2 * LO_W)) + (RAD_W'(hlh_reg) << (LO_W + 1))
                        + RAD_W'(hll_reg);
            acm_reg    <= (RAD_W'(achh_reg) << (2 * LO_W))
                        + ((RAD_W'(aclh_reg) + RAD_W'(achl_reg)) << LO_W)
                        + RAD_W'(acll_reg);
            acneg4_reg <= acneg3_reg;
            anz4_reg   <= anz3_reg;
        end
    end

    // stage 5: discriminant and body enable
    logic signed [RAD_W:0] acs, disc;
    logic                  ben5;
    always_comb
    begin
        acs  = $signed({1'b0, acm_reg});
        disc = $signed({1'b0, hsq_reg}) - (acneg4_reg ? -acs : acs);
        ben5 = anz4_reg && !disc[RAD_W];
    end

    logic [RAD_W-1:0] rad_reg;
    logic             ben_reg [L_DISC:L_R2];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg         <= ben5 ? disc[RAD_W-1:0] : '0;
            ben_reg[L_DISC] <= ben5;
        end
    end
    for (genvar l = L_DISC + 1; l <= L_R2; l++) begin : g_ben_line
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ben_reg[l] <= ben_reg[l-1];
            end
        end
    end

    // square root, one result bit per stage
    logic [RAD_W-1:0]    sq_rad_reg  [0:SQ_STEPS-2];
    logic [SQ_REM_W-1:0] sq_rem_reg  [0:SQ_STEPS-2];
    logic [SQ_W-1:0]     sq_root_reg [0:SQ_STEPS-1];
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        logic [RAD_W-1:0]    rad_in;
        logic [SQ_REM_W-1:0] rem_in, cur, trial;
        logic [SQ_W-1:0]     root_in;
        logic                ge;

        if (i == 0) begin : g_first
            assign rad_in  = rad_reg;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign rad_in  = sq_rad_reg[i-1];
            assign rem_in  = sq_rem_reg[i-1];
            assign root_in = sq_root_reg[i-1];
        end

        assign cur   = {rem_in[SQ_REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_root_reg[i] <= {root_in[SQ_W-2:0], ge};
            end
        end

        if (i < SQ_STEPS - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_rad_reg[i] <= rad_in << 2;
                    sq_rem_reg[i] <= ge ? cur - trial : cur;
                end
            end
        end
    end

    // numerators and divisor magnitudes for the two body roots and the cap
    logic signed [NUM_W-1:0] n0, n1, hx, sx;
    logic signed [CN_W-1:0]  cn;
    logic [CN_W-1:0]         cn_m;
    logic [NUM_W-1:0]        n0_m, n1_m;
    logic [COORD_W-1:0]      dy_m;
    ray_word_t               rn;
    always_comb
    begin
        rn   = ray_reg[L_SQ_END];
        hx   = NUM_W'(h_reg[L_SQ_END]);
        sx   = $signed({2'b00, sq_root_reg[SQ_STEPS-1]});
        n0   = sx - hx;
        n1   = -hx - sx;
        n0_m = n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
        n1_m = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
        cn   = -HALF_ONE - CN_W'(rn.origin_y);
        cn_m = cn[CN_W-1] ? CN_W'(-cn) : CN_W'(cn);
        dy_m = rn.dir_y[COORD_W-1] ? COORD_W'(-rn.dir_y) : COORD_W'(rn.dir_y);
    end

    logic [DIV_N_W-1:0] dn0_reg, dn1_reg, dnc_reg;
    logic [DIV_D_W-1:0] da_reg, dd_reg;
    logic               neg0_reg, neg1_reg, negc_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dn0_reg  <= {n0_m[NUM_W-2:0], FRAC_BITS'(0)};
            dn1_reg  <= {n1_m[NUM_W-2:0], FRAC_BITS'(0)};
            dnc_reg  <= DIV_N_W'({cn_m[CN_W-2:0], FRAC_BITS'(0)});
            da_reg   <= mag_abc(a_reg[L_SQ_END]);
            dd_reg   <= DIV_D_W'(dy_m);
            neg0_reg <= n0[NUM_W-1] ^ a_reg[L_SQ_END][ABC_W-1];
            neg1_reg <= n1[NUM_W-1] ^ a_reg[L_SQ_END][ABC_W-1];
            negc_reg <= cn[CN_W-1] ^ rn.dir_y[COORD_W-1];
        end
    end

    // dividers, truncating toward zero with saturation
    logic signed [COORD_W-1:0] q0, q1, qc;
    rci_div u_div_near (.clk(clk), .en(adv), .n_mag(dn0_reg), .d_mag(da_reg),
                        .neg(neg0_reg), .quo(q0));
    rci_div u_div_far  (.clk(clk), .en(adv), .n_mag(dn1_reg), .d_mag(da_reg),
                        .neg(neg1_reg), .quo(q1));
    rci_div u_div_cap  (.clk(clk), .en(adv), .n_mag(dnc_reg), .d_mag(dd_reg),
                        .neg(negc_reg), .quo(qc));

    // distance delay lines
    logic signed [COORD_W-1:0] t0_reg [L_TPROD:L_R2];
    logic signed [COORD_W-1:0] t1_reg [L_TPROD:L_R2];
    logic signed [COORD_W-1:0] tc_reg [L_TPROD:L_R2];
    for (genvar l = L_TPROD + 1; l <= L_R2; l++) begin : g_t_line
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                t0_reg[l] <= t0_reg[l-1];
                t1_reg[l] <= t1_reg[l-1];
                tc_reg[l] <= tc_reg[l-1];
            end
        end
    end

    // hit point products
    logic signed [PROD_W-1:0] t0dy_reg, t0dz_reg, t1dy_reg, t1dz_reg, tcdx_reg, tcdz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg[L_TPROD] <= q0;
            t1_reg[L_TPROD] <= q1;
            tc_reg[L_TPROD] <= qc;
            t0dy_reg <= q0 * ray_reg[L_DIV].dir_y;
            t0dz_reg <= q0 * ray_reg[L_DIV].dir_z;
            t1dy_reg <= q1 * ray_reg[L_DIV].dir_y;
            t1dz_reg <= q1 * ray_reg[L_DIV].dir_z;
            tcdx_reg <= qc * ray_reg[L_DIV].dir_x;
            tcdz_reg <= qc * ray_reg[L_DIV].dir_z;
        end
    end

    // hit points: body slab tests, cap point magnitudes
    logic signed [PT_W-1:0] y0, z0, y1, z1, xc, zc;
    logic                   in0, in1, cap_box;
    ray_word_t              rp;
    always_comb
    begin
        rp      = ray_reg[L_TPROD];
        y0      = (PT_W'(rp.origin_y) <<< FRAC_BITS) + PT_W'(t0dy_reg);
        z0      = (PT_W'(rp.origin_z) <<< FRAC_BITS) + PT_W'(t0dz_reg);
        y1      = (PT_W'(rp.origin_y) <<< FRAC_BITS) + PT_W'(t1dy_reg);
        z1      = (PT_W'(rp.origin_z) <<< FRAC_BITS) + PT_W'(t1dz_reg);
        xc      = (PT_W'(rp.origin_x) <<< FRAC_BITS) + PT_W'(tcdx_reg);
        zc      = (PT_W'(rp.origin_z) <<< FRAC_BITS) + PT_W'(tcdz_reg);
        in0     = (y0 > -HALF2) && (y0 < HALF2) && (z0 > -HALF2) && (z0 < HALF2);
        in1     = (y1 > -HALF2) && (y1 < HALF2) && (z1 > -HALF2) && (z1 < HALF2);
        cap_box = (xc >= -HALF2) && (xc <= HALF2) && (zc >= -HALF2) && (zc <= HALF2);
    end

    logic [XM_W-1:0] xm_reg, zm_reg;
    logic            in0_reg [L_HITPT:L_R2];
    logic            in1_reg [L_HITPT:L_R2];
    logic            cap_box_reg [L_HITPT:L_RPART];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xm_reg               <= xc[PT_W-1] ? XM_W'(-xc) : XM_W'(xc);
            zm_reg               <= zc[PT_W-1] ? XM_W'(-zc) : XM_W'(zc);
            in0_reg[L_HITPT]     <= in0;
            in1_reg[L_HITPT]     <= in1;
            cap_box_reg[L_HITPT] <= cap_box;
            cap_box_reg[L_RPART] <= cap_box_reg[L_HITPT];
            in0_reg[L_RPART]     <= in0_reg[L_HITPT];
            in1_reg[L_RPART]     <= in1_reg[L_HITPT];
            in0_reg[L_R2]        <= in0_reg[L_RPART];
            in1_reg[L_R2]        <= in1_reg[L_RPART];
        end
    end

    // cap radius: partial products, then sum and compare
    logic [XM_W-1:0] xll_reg, xlh_reg, xhh_reg, zll_reg, zlh_reg, zhh_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xll_reg <= xm_reg[XH_W-1:0] * xm_reg[XH_W-1:0];
            xlh_reg <= xm_reg[XH_W-1:0] * xm_reg[XM_W-1:XH_W];
            xhh_reg <= xm_reg[XM_W-1:XH_W] * xm_reg[XM_W-1:XH_W];
            zll_reg <= zm_reg[XH_W-1:0] * zm_reg[XH_W-1:0];
            zlh_reg <= zm_reg[XH_W-1:0] * zm_reg[XM_W-1:XH_W];
            zhh_reg <= zm_reg[XM_W-1:XH_W] * zm_reg[XM_W-1:XH_W];
        end
    end

    logic [R2_W-1:0] r2;
    assign r2 = (R2_W'(xhh_reg) << XM_W) + (R2_W'(xlh_reg) << (XH_W + 1)) + R2_W'(xll_reg)
              + (R2_W'(zhh_reg) << XM_W) + (R2_W'(zlh_reg) << (XH_W + 1)) + R2_W'(zll_reg);

    logic capin_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            capin_reg <= cap_box_reg[L_RPART] && (r2 <= R2_LIM);
        end
    end

    // nearest accepted hit: near root, far root, then cap
    logic signed [CMP_W-1:0] tol_s, best0, best1, best2, t0s, t1s, tcs;
    logic                    ok0, ok1, okc;
    ray_word_t               rd;
    hit_word_t               out_next;
    always_comb
    begin
        rd    = ray_reg[L_R2];
        tol_s = $signed(CMP_W'(tol_reg));
        t0s   = CMP_W'(t0_reg[L_R2]);
        t1s   = CMP_W'(t1_reg[L_R2]);
        tcs   = CMP_W'(tc_reg[L_R2]);
        best0 = (rd.max_distance == DIST_MAX) ? (CMP_W'(1) <<< DIST_W)
                                              : $signed(CMP_W'(rd.max_distance));
        ok0   = ben_reg[L_R2] && in0_reg[L_R2] && (t0s > tol_s) && (t0s < best0);
        best1 = ok0 ? t0s : best0;
        ok1   = ben_reg[L_R2] && in1_reg[L_R2] && (t1s > tol_s) && (t1s < best1);
        best2 = ok1 ? t1s : best1;
        okc   = (rd.dir_y != '0) && capin_reg && (tcs > tol_s) && (tcs < best2);
        out_next.hit      = ok0 || ok1 || okc;
        out_next.distance = okc ? tcs[DIST_W-1:0]
                          : (ok0 || ok1) ? best2[DIST_W-1:0] : DIST_MAX;
        out_next.surface  = okc;
    end

    // output register
    hit_word_t out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign hit_valid = v_reg[L_OUT];
    assign hit_info  = out_reg;

`ifndef NO_ASSERTIONS
    a_surface_hit: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_info.surface |-> hit_info.hit)
        else $error("cap surface flagged without a hit");

    a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_info.hit |-> hit_info.distance == DIST_MAX)
        else $error("miss word carries a finite distance");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        ray_stall |=> $stable(v_reg))
        else $error("valid bits moved during a stall");

    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && !ray_stall |=> v_reg[1])
        else $error("accepted ray word not in first stage");
`endif

endmodule

// File: dv/tb_ray_cone_intersect.sv
module tb_ray_cone_intersect;
    import rci_pkg::*;

    localparam longint ONE  = 64'sd1 << FRAC_BITS;
    localparam longint HALF = ONE / 2;

    // Scoreboard: predicts one hit word per accepted ray word, in order
    class cone_scoreboard;
        hit_word_t pending_hits[$];
        logic [TOL_W-1:0] tol;
        int errors;

        function new();
            tol = TOL_RESET;
            errors = 0;
        endfunction

        // nearest cone hit for one ray at the current tolerance
        function hit_word_t predict_hit(ray_word_t r);
            logic signed [127:0] px, py, pz, dx, dy, dz, one_w, half2;
            logic signed [127:0] t4, t8, t16, a, h, c, disc, num, t, y, z, x, best, tolw, lim;
            logic [127:0] disc_u, sq, r2;
            logic [63:0] s, cand;
            logic hit, cap;
            hit_word_t res;
            px = r.origin_x; py = r.origin_y; pz = r.origin_z;
            dx = r.dir_x;    dy = r.dir_y;    dz = r.dir_z;
            one_w = ONE;
            half2 = 128'sd1 <<< (2 * FRAC_BITS - 1);
            lim = 128'(DIST_MAX);
            tolw = 128'(tol);
            best = (r.max_distance == DIST_MAX) ? lim + 1 : 128'(r.max_distance);
            hit = 1'b0;
            cap = 1'b0;

            // quadratic terms, floored to the fixed-point grid
            t4 = 4 * dx * dx + 4 * dz * dz - dy * dy;
            a = t4 >>> (FRAC_BITS + 2);
            t8 = 8 * px * dx + 8 * pz * dz - 2 * py * dy + dy * one_w;
            h = t8 >>> (FRAC_BITS + 3);
            t16 = 16 * px * px + 16 * pz * pz - 4 * py * py + 4 * py * one_w - one_w * one_w;
            c = t16 >>> (FRAC_BITS + 4);
            disc = h * h - a * c;

            // body: both roots, y and z strictly inside the half-unit slab
            if (a != 0 && disc >= 0) begin
                disc_u = disc;
                s = '0;
                for (int b = 63; b >= 0; b--) begin
                    cand = s | (64'd1 << b);
                    sq = {64'd0, cand} * {64'd0, cand};
                    if (sq <= disc_u)
                        s = cand;
                end
                for (int k = 0; k < 2; k++) begin
                    num = (k == 0) ? -h + $signed({64'd0, s}) : -h - $signed({64'd0, s});
                    t = (num * one_w) / a;
                    if (t > lim) t = lim;
                    if (t < -lim) t = -lim;
                    if (t > tolw && t < best) begin
                        y = py * one_w + t * dy;
                        z = pz * one_w + t * dz;
                        if (y > -half2 && y < half2 && z > -half2 && z < half2) begin
                            best = t;
                            hit = 1'b1;
                        end
                    end
                end
            end

            // base cap at y = -0.5, radius 0.5; wins only when strictly nearer
            if (dy != 0) begin
                num = (-(one_w >>> 1) - py) * one_w;
                t = num / dy;
                if (t > lim) t = lim;
                if (t < -lim) t = -lim;
                if (t > tolw && t < best) begin
                    x = px * one_w + t * dx;
                    z = pz * one_w + t * dz;
                    r2 = x * x + z * z;
                    if (r2 <= (128'd1 << (4 * FRAC_BITS - 2))) begin
                        best = t;
                        hit = 1'b1;
                        cap = 1'b1;
                    end
                end
            end

            res.hit = hit;
            res.distance = hit ? best[DIST_W-1:0] : DIST_MAX;
            res.surface = cap;
            return res;
        endfunction

        function void note_ray(ray_word_t r);
            pending_hits.push_back(predict_hit(r));
        endfunction

        function void check_hit(hit_word_t got);
            hit_word_t exp_w;
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected hit word %p", $time, got);
                errors++;
                return;
            end
            exp_w = pending_hits.pop_front();
            if (got.hit !== exp_w.hit) begin
                $display("%0t: hit expected %0d got %0d", $time, exp_w.hit, got.hit);
                errors++;
            end
            if (got.distance !== exp_w.distance) begin
                $display("%0t: distance expected %0d got %0d", $time,
                         exp_w.distance, got.distance);
                errors++;
            end
            if (got.surface !== exp_w.surface) begin
                $display("%0t: surface expected %0d got %0d", $time,
                         exp_w.surface, got.surface);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic ray_valid = 1'b0;
    logic ray_stall;
    ray_word_t ray = '0;
    logic hit_valid;
    logic hit_stall = 1'b0;
    hit_word_t hit_info;
    logic cfg_we = 1'b0;
    logic [TOL_W-1:0] cfg_data = '0;

    cone_scoreboard sb = new();
    int gap_pct = 18;
    int stall_pct = 18;
    int hold_left = 0;

    ray_cone_intersect dut (
        .clk(clk), .rst_n(rst_n),
        .ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
        .hit_valid(hit_valid), .hit_stall(hit_stall), .hit_info(hit_info),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // accepted words on both channels
    always @(posedge clk)
    begin
        if (rst_n && ray_valid && !ray_stall)
            sb.note_ray(ray);
        if (rst_n && hit_valid && !hit_stall)
            sb.check_hit(hit_info);
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hit_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            hit_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic ray_word_t mk_ray(longint px, longint py, longint pz,
                                         longint dx, longint dy, longint dz, longint md);
        ray_word_t r;
        r.origin_x = px[31:0]; r.origin_y = py[31:0]; r.origin_z = pz[31:0];
        r.dir_x = dx[31:0];    r.dir_y = dy[31:0];    r.dir_z = dz[31:0];
        r.max_distance = md[30:0];
        return r;
    endfunction

    // mostly rays aimed near the cone, some raw noise and degenerate rays
    function automatic ray_word_t rand_ray();
        ray_word_t r;
        longint o[3], tg[3], d[3];
        int kind, sh;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 31'($urandom)};
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            o[i] = longint'($signed($urandom_range(0, 32'h0400_0000))) - 64'sh0200_0000;
            tg[i] = longint'($signed($urandom_range(0, 32'h0140_0000))) - 64'sh00A0_0000;
            d[i] = tg[i] - o[i];
        end
        sh = $urandom_range(0, 4);
        for (int i = 0; i < 3; i++)
            d[i] = ($urandom_range(1)) ? (d[i] >>> sh) : (d[i] <<< (sh > 2 ? 2 : sh));
        if (kind < 25)
            d[$urandom_range(2)] = 0;
        else if (kind < 30)
            o[1] = -HALF;
        r = mk_ray(o[0], o[1], o[2], d[0], d[1], d[2],
                   ($urandom_range(99) < 75) ? 64'(DIST_MAX)
                                             : longint'($urandom_range(0, 32'h7FFF_FFFF)));
        return r;
    endfunction

    task automatic send_ray(ray_word_t r);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            ray_valid <= 1'b0;
        end
        @(negedge clk);
        ray_valid <= 1'b1;
        ray <= r;
        do
            @(posedge clk);
        while (ray_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        ray_valid <= 1'b0;
        while (sb.pending_hits.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_tol(logic [TOL_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.tol = v;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_ray(rand_ray());
    endtask

    // run timeout
    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        longint dm;
        dm = 64'(DIST_MAX);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rays at the reset tolerance
        send_ray(mk_ray(0, 0, 0, 0, 0, 0, dm));
        send_ray({{6{32'hFFFF_FFFF}}, 31'h7FFF_FFFF});
        send_ray({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 31'h0});
        send_ray({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF});
        send_ray(mk_ray(-2 * ONE, 0, 0, ONE, 0, 0, dm));          // horizontal, body, no cap
        send_ray(mk_ray(-2 * ONE, 0, 0, ONE, 0, 0, ONE));         // limit cuts it off
        send_ray(mk_ray(0, -2 * ONE, 0, 0, ONE, 0, dm));          // from below, cap
        send_ray(mk_ray(0, 2 * ONE, 0, 0, -ONE, 0, dm));          // from above, tip
        send_ray(mk_ray(0, 0, 0, HALF, ONE, 0, dm));              // zero a
        send_ray(mk_ray(3 * ONE, 0, 3 * ONE, 0, ONE, 0, dm));     // miss, body roots outside slab
        send_ray(mk_ray(0, 0, 0, 1, 1, 1, dm));                   // saturated t, unbounded
        send_ray(mk_ray(0, 0, 0, 1, -1, 1, dm - 1));              // saturated t, bounded
        send_ray(mk_ray(0, -HALF, 0, ONE, 0, 0, dm));             // in the base plane
        send_ray(mk_ray(HALF, -ONE, 0, 0, ONE, 0, dm));           // cap rim
        send_ray(mk_ray(0, 0, -2 * ONE, 0, 0, ONE, dm));          // along z
        send_ray(mk_ray(0, 0, 0, ONE, 0, 0, dm));                 // from inside
        send_ray(mk_ray(0, 0, 0, 0, -ONE, 0, 1));                 // limit of one lsb
        run_random(300);
        drain();

        // tolerance of zero and of one unit, and a random one
        write_tol(0);
        send_ray(mk_ray(0, -HALF, 0, 0, ONE, 0, dm));
        send_ray(mk_ray(0, 0, 0, ONE, 0, 0, dm));
        run_random(300);
        drain();
        write_tol(TOL_W'(ONE));
        run_random(300);
        drain();
        write_tol(TOL_W'($urandom_range(0, 32'h0100_0000)));
        run_random(300);
        drain();
        write_tol(TOL_RESET);

        // long receiver hold-off while rays keep coming
        hold_left = 400;
        run_random(250);
        drain();

        // no idling on either side
        gap_pct = 0;
        stall_pct = 0;
        run_random(250);
        gap_pct = 18;
        stall_pct = 18;
        run_random(200);
        drain();

        if (sb.errors == 0 && sb.pending_hits.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
